// ===== hdl/seg14_pkg.sv =====
// seg14_pkg: shared types and constants of the 14-segment text entry display
// edit commands, payload structs of both channels and the font lookup result
// no dependencies
`default_nettype none

package seg14_pkg;

  localparam int NumDigitsDef = 5;
  localparam int NumSegments  = 14;
  localparam int OutDigits    = 5;

  typedef logic [NumSegments-1:0] seg14_seg_t;

  typedef enum logic [2:0] {
    CMD_CHAR      = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_LEFT      = 3'd3,
    CMD_RIGHT     = 3'd4
  } seg14_cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] key_char;
  } seg14_in_t;

  typedef struct packed {
    logic [NumSegments-1:0] digit0_segments;
    logic [NumSegments-1:0] digit1_segments;
    logic [NumSegments-1:0] digit2_segments;
    logic [NumSegments-1:0] digit3_segments;
    logic [NumSegments-1:0] digit4_segments;
    logic [2:0]             cursor_position;
    logic                   char_found;
  } seg14_out_t;

  typedef struct packed {
    logic       found;
    seg14_seg_t pattern;
  } seg14_glyph_t;

endpackage

`default_nettype wire

// ===== hdl/segment14_text_entry_display.sv =====
// segment14_text_entry_display: top level with input register and result register
// depends on seg14_pkg, seg14_font and seg14_editor
//
// Takes one edit event (character, backspace, delete, left, right) per clock
// and returns one result per event: all five digit patterns, the cursor and
// the font match flag after that event. Throughput is one event per cycle
// while the output does not stall; each event passes through the input
// register and then the result register, with the font lookup and the
// cursor/digit update between them. A stall on the output holds the result
// register and backs up into the input register; the editor state only
// advances when an event moves into the result register.
`default_nettype none

module segment14_text_entry_display #(
  parameter int NUM_DIGITS = seg14_pkg::NumDigitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire seg14_pkg::seg14_in_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output seg14_pkg::seg14_out_t  out_data_o
);
  import seg14_pkg::*;

  logic         in_valid_q, out_valid_q, adv, fire;
  seg14_in_t    in_q;
  seg14_out_t   out_q, res;
  seg14_glyph_t glyph;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  seg14_font u_font (
    .key_char_i (in_q.key_char),
    .glyph_o    (glyph)
  );

  seg14_editor #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_editor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .in_i    (in_q),
    .glyph_i (glyph),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/seg14_font.sv =====
// seg14_font: case folding and font table lookup for one character code
// depends on seg14_pkg
`default_nettype none

module seg14_font (
  input  wire logic [7:0]             key_char_i,
  output seg14_pkg::seg14_glyph_t     glyph_o
);
  import seg14_pkg::*;

  localparam logic [7:0] CaseOffset = 8'h20;

  logic [7:0] code;

  always_comb begin
    code = key_char_i;
    if (key_char_i >= "A" && key_char_i <= "Z") begin
      code = key_char_i + CaseOffset;
    end
  end

  always_comb begin
    glyph_o.found = 1'b1;
    case (code)
      " ": glyph_o.pattern = 14'h0000;
      "a": glyph_o.pattern = 14'h11E3;
      "b": glyph_o.pattern = 14'h34A9;
      "c": glyph_o.pattern = 14'h2103;
      "d": glyph_o.pattern = 14'h3429;
      "e": glyph_o.pattern = 14'h2143;
      "f": glyph_o.pattern = 14'h0143;
      "g": glyph_o.pattern = 14'h3183;
      "h": glyph_o.pattern = 14'h11E2;
      "i": glyph_o.pattern = 14'h2409;
      "j": glyph_o.pattern = 14'h1821;
      "k": glyph_o.pattern = 14'h0952;
      "l": glyph_o.pattern = 14'h2102;
      "m": glyph_o.pattern = 14'h1136;
      "n": glyph_o.pattern = 14'h1926;
      "o": glyph_o.pattern = 14'h3123;
      "p": glyph_o.pattern = 14'h01E3;
      "q": glyph_o.pattern = 14'h3923;
      "r": glyph_o.pattern = 14'h09E3;
      "s": glyph_o.pattern = 14'h30C3;
      "t": glyph_o.pattern = 14'h0409;
      "u": glyph_o.pattern = 14'h3122;
      "v": glyph_o.pattern = 14'h0312;
      "w": glyph_o.pattern = 14'h1B22;
      "x": glyph_o.pattern = 14'h0A14;
      "y": glyph_o.pattern = 14'h0214;
      "z": glyph_o.pattern = 14'h2211;
      "0": glyph_o.pattern = 14'h3333;
      "1": glyph_o.pattern = 14'h0408;
      "2": glyph_o.pattern = 14'h22A1;
      "3": glyph_o.pattern = 14'h3091;
      "4": glyph_o.pattern = 14'h04CA;
      "5": glyph_o.pattern = 14'h2843;
      "6": glyph_o.pattern = 14'h31C3;
      "7": glyph_o.pattern = 14'h0211;
      "8": glyph_o.pattern = 14'h31E3;
      "9": glyph_o.pattern = 14'h30E3;
      "-": glyph_o.pattern = 14'h00C0;
      "+": glyph_o.pattern = 14'h04C8;
      "%": glyph_o.pattern = 14'h1AD6;
      default: begin
        glyph_o.found   = 1'b0;
        glyph_o.pattern = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/seg14_editor.sv =====
// seg14_editor: cursor and digit pattern registers with the edit command logic
// depends on seg14_pkg; takes the glyph from seg14_font
`default_nettype none

module seg14_editor #(
  parameter int NUM_DIGITS = seg14_pkg::NumDigitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   fire_i,
  input  wire seg14_pkg::seg14_in_t    in_i,
  input  wire seg14_pkg::seg14_glyph_t glyph_i,
  output seg14_pkg::seg14_out_t       res_o
);
  import seg14_pkg::*;

  localparam int CW  = $clog2(NUM_DIGITS + 1);
  localparam int CXW = (CW > 3) ? CW : 3;
  localparam logic [CW-1:0] CurEnd  = CW'(NUM_DIGITS);
  localparam logic [CW-1:0] CurLast = CW'(NUM_DIGITS - 1);

  logic [CW-1:0]  cursor_q, cursor_d;
  logic [CW-1:0]  cur_dec, cur_right, wr_idx;
  logic [CW:0]    cur_inc;
  logic [CXW-1:0] cur_x;
  logic           wr_en, found;
  seg14_seg_t     wr_val;
  seg14_seg_t     digit_q [NUM_DIGITS];
  seg14_seg_t     digit_d [NUM_DIGITS];
  seg14_seg_t     res_dig [OutDigits];

  always_comb begin
    cur_dec   = (cursor_q != '0) ? cursor_q - CW'(1) : '0;
    cur_inc   = {1'b0, cursor_q} + (CW+1)'(1);
    cur_right = (cur_inc < {1'b0, CurLast}) ? cur_inc[CW-1:0] : CurLast;
  end

  always_comb begin
    cursor_d = cursor_q;
    wr_en    = 1'b0;
    wr_idx   = cursor_q;
    wr_val   = '0;
    found    = 1'b0;
    unique case (seg14_cmd_e'(in_i.cmd))
      CMD_CHAR: begin
        if (glyph_i.found) begin
          found = 1'b1;
          if (cursor_q < CurEnd) begin
            wr_en    = 1'b1;
            wr_val   = glyph_i.pattern;
            cursor_d = cursor_q + CW'(1);
          end
        end
      end
      CMD_BACKSPACE: begin
        cursor_d = cur_dec;
        wr_en    = 1'b1;
        wr_idx   = cur_dec;
      end
      CMD_DELETE: begin
        wr_en = (cursor_q < CurEnd);
      end
      CMD_LEFT:  cursor_d = cur_dec;
      CMD_RIGHT: cursor_d = cur_right;
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digit_d[i] = (wr_en && wr_idx == CW'(i)) ? wr_val : digit_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i] <= '0;
      end
    end else if (fire_i) begin
      cursor_q <= cursor_d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i] <= digit_d[i];
      end
    end
  end

  // digits past the configured count read as blank
  for (genvar k = 0; k < OutDigits; k++) begin : g_res
    if (k < NUM_DIGITS) begin : g_used
      assign res_dig[k] = digit_d[k];
    end else begin : g_blank
      assign res_dig[k] = '0;
    end
  end

  assign cur_x = CXW'(cursor_d);

  always_comb begin
    res_o.digit0_segments = res_dig[0];
    res_o.digit1_segments = res_dig[1];
    res_o.digit2_segments = res_dig[2];
    res_o.digit3_segments = res_dig[3];
    res_o.digit4_segments = res_dig[4];
    res_o.cursor_position = cur_x[2:0];
    res_o.char_found      = found;
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CurEnd)
    else $error("cursor beyond end position");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(cursor_q))
    else $error("cursor moved without a transfer");

  a_unknown_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && in_i.cmd == CMD_CHAR && !glyph_i.found |=> $stable(cursor_q))
    else $error("unknown character moved the cursor");

  a_found_only_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.char_found |-> in_i.cmd == CMD_CHAR)
    else $error("match flag on a non-character command");

  a_right_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && in_i.cmd == CMD_RIGHT |=> cursor_q <= CurLast)
    else $error("cursor right passed the last digit");

endmodule

`default_nettype wire
